### rtl/acf_pkg.sv
// Shared types, constants and the AES S-box for the frame encryptor.
package acf_pkg;

  localparam int HEADER_BYTES    = 3;
  localparam int MAX_PAYLOAD_DEF = 255;
  localparam int IN_FIFO_DEPTH   = 4;
  localparam int OUT_FIFO_DEPTH  = 8;
  localparam int MAC_TAIL_SKIP   = 3;

  localparam logic [7:0]   B0_FLAG  = 8'd89;
  localparam logic [7:0]   CTR_FLAG = 8'd1;
  localparam logic [15:0]  SUM_MASK = 16'hFFFF;
  localparam logic [127:0] FIXED_BLOCK = 128'h97CFB802844143DE56002B3B34780A5D;

  // Configuration register indexes
  localparam logic [1:0] REG_KEY_LOW  = 2'd0;
  localparam logic [1:0] REG_KEY_HIGH = 2'd1;
  localparam logic [1:0] REG_NONCE    = 2'd2;

  typedef enum logic [1:0] {
    KIND_HDR,
    KIND_PAY,
    KIND_DROP
  } kind_e;

  // One classified word handed from the front to the back
  typedef struct packed {
    logic [7:0]  data;
    logic [31:0] ctr;
    logic [7:0]  mac_len;
    kind_e       kind;
    logic        first;
    logic [3:0]  k;
    logic        in_mac;
    logic        mac_end;
    logic        fin_abs;
    logic        last;
  } item_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] sbox_f(input logic [7:0] a);
    return SBOX[a];
  endfunction

  function automatic logic [7:0] xtime_f(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte k of a 128-bit block, byte 0 in the top bits
  function automatic logic [7:0] get_byte_f(input logic [127:0] b, input logic [3:0] k);
    return b[{4'd15 - k, 3'b000} +: 8];
  endfunction

endpackage

### rtl/acf_fifo.sv
// Small register queue with head-of-queue read.
module acf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             rd_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wp_q, rp_q;
  logic [CW-1:0]    cnt_q;
  logic             do_wr, do_rd;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_wr) begin
        wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
      end
      if (do_rd) begin
        rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end
endmodule

### rtl/acf_aes.sv
// Round-iterative AES-128 encryption core, key schedule computed on the fly.
module acf_aes import acf_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [127:0] key_i,
  input  logic [127:0] blk_i,
  output logic         done_o,
  output logic [127:0] blk_o
);
  logic [127:0] st_q, rk_q, nrk, sr, mc, st_d;
  logic [7:0]   rcon_q;
  logic [3:0]   rnd_q;
  logic         busy_q, done_q;
  logic [31:0]  w0, w1, w2, w3, tw, n0, n1, n2, n3;

  // Next round key
  always_comb begin
    w0 = rk_q[127:96];
    w1 = rk_q[95:64];
    w2 = rk_q[63:32];
    w3 = rk_q[31:0];
    tw = {sbox_f(w3[23:16]) ^ rcon_q, sbox_f(w3[15:8]), sbox_f(w3[7:0]), sbox_f(w3[31:24])};
    n0 = w0 ^ tw;
    n1 = w1 ^ n0;
    n2 = w2 ^ n1;
    n3 = w3 ^ n2;
    nrk = {n0, n1, n2, n3};
  end

  // SubBytes and ShiftRows
  always_comb begin
    sr = '0;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        sr[(15 - (i + 4 * c)) * 8 +: 8] =
          sbox_f(st_q[(15 - (i + 4 * ((c + i) % 4))) * 8 +: 8]);
      end
    end
  end

  // MixColumns
  always_comb begin
    logic [7:0] m0, m1, m2, m3, al;
    mc = '0;
    for (int c = 0; c < 4; c++) begin
      m0 = sr[(15 - 4 * c) * 8 +: 8];
      m1 = sr[(14 - 4 * c) * 8 +: 8];
      m2 = sr[(13 - 4 * c) * 8 +: 8];
      m3 = sr[(12 - 4 * c) * 8 +: 8];
      al = m0 ^ m1 ^ m2 ^ m3;
      mc[(15 - 4 * c) * 8 +: 8] = m0 ^ al ^ xtime_f(m0 ^ m1);
      mc[(14 - 4 * c) * 8 +: 8] = m1 ^ al ^ xtime_f(m1 ^ m2);
      mc[(13 - 4 * c) * 8 +: 8] = m2 ^ al ^ xtime_f(m2 ^ m3);
      mc[(12 - 4 * c) * 8 +: 8] = m3 ^ al ^ xtime_f(m3 ^ m0);
    end
  end

  assign st_d   = ((rnd_q == 4'd10) ? sr : mc) ^ nrk;
  assign done_o = done_q;
  assign blk_o  = st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      rnd_q  <= '0;
      rcon_q <= 8'h01;
      st_q   <= '0;
      rk_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        st_q   <= blk_i ^ key_i;
        rk_q   <= key_i;
        rcon_q <= 8'h01;
        rnd_q  <= 4'd1;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        st_q   <= st_d;
        rk_q   <= nrk;
        rcon_q <= xtime_f(rcon_q);
        rnd_q  <= rnd_q + 4'd1;
        if (rnd_q == 4'd10) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end
endmodule

### rtl/acf_front.sv
// Front end: tracks frame position, classifies each word and queues it.
module acf_front import acf_pkg::*; #(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        full_o,
  input  logic [7:0]  data_byte_i,
  input  logic [31:0] msg_counter_i,
  input  logic [7:0]  payload_length_i,
  input  logic        last_byte_i,
  input  logic        pop_i,
  output item_t       item_o,
  output logic        empty_o
);
  localparam int PW = $clog2(MAX_PAYLOAD + HEADER_BYTES + 1);
  localparam int CW = (PW > 8) ? PW : 8;

  logic [PW-1:0] pos_q;
  logic [CW-1:0] pos_w, q, pos_n, tk, ml_w;
  logic [7:0]    mac_len;
  item_t         it;
  logic          acc;

  assign acc = push_i && !full_o;

  always_comb begin
    mac_len = (payload_length_i >= 8'(MAC_TAIL_SKIP)) ?
              payload_length_i - 8'(MAC_TAIL_SKIP) : 8'd0;
    ml_w  = CW'(mac_len);
    pos_w = CW'(pos_q);
    q     = pos_w - CW'(HEADER_BYTES);
    it.data    = data_byte_i;
    it.ctr     = msg_counter_i;
    it.mac_len = mac_len;
    it.first   = (pos_q == '0);
    it.last    = last_byte_i;
    it.in_mac  = 1'b0;
    it.mac_end = 1'b0;
    if (pos_w < CW'(HEADER_BYTES)) begin
      it.kind    = KIND_HDR;
      it.k       = pos_w[3:0];
      it.mac_end = (pos_w == CW'(HEADER_BYTES - 1));
      pos_n      = pos_w + 1'b1;
    end else if (q < CW'(MAX_PAYLOAD)) begin
      it.kind    = KIND_PAY;
      it.k       = q[3:0];
      it.in_mac  = (q < ml_w);
      it.mac_end = it.in_mac && ((q[3:0] == 4'd15) || (q == ml_w - 1'b1));
      pos_n      = pos_w + 1'b1;
    end else begin
      it.kind    = KIND_DROP;
      it.k       = q[3:0];
      pos_n      = pos_w;
    end
    // Pad and absorb a partly gathered block at the end of the frame
    tk = pos_n - CW'(HEADER_BYTES);
    if (pos_n < CW'(HEADER_BYTES)) begin
      it.fin_abs = 1'b1;
    end else begin
      it.fin_abs = (tk < ml_w) && (tk[3:0] != 4'd0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (acc) begin
      pos_q <= last_byte_i ? '0 : pos_n[PW-1:0];
    end
  end

  acf_fifo #(
    .WIDTH($bits(item_t)),
    .DEPTH(IN_FIFO_DEPTH)
  ) u_in_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (acc),
    .wdata_i(it),
    .rd_i   (pop_i),
    .rdata_o(item_o),
    .full_o (full_o),
    .empty_o(empty_o)
  );
endmodule

### rtl/acf_back.sv
// Back end: sequences AES jobs, keystream XOR, MAC chaining and trailer.
module acf_back import acf_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [127:0] key_i,
  input  logic [63:0]  nonce_i,
  input  item_t        item_i,
  input  logic         item_empty_i,
  output logic         item_pop_o,
  output logic [7:0]   out_byte_o,
  output logic         last_out_o,
  output logic         empty_o,
  input  logic         pop_i
);
  typedef enum logic [3:0] {
    ST_IDLE, ST_HEAD, ST_B0W, ST_BODY, ST_KSW, ST_PAY, ST_EMIT, ST_POST,
    ST_ABSW, ST_LAST, ST_FABW, ST_TRLS, ST_S0W, ST_TRL
  } state_e;

  state_e       state_q, state_d;
  item_t        cur_q, cur_d;
  logic [127:0] chain_q, chain_d, gath_q, gath_d, ks_q, ks_d;
  logic [15:0]  sum_q, sum_d, csum;
  logic [7:0]   bidx_q, bidx_d, emit_q, emit_d, trl;
  logic [2:0]   cnt_q, cnt_d;
  logic         aes_start, aes_done, ofull, opush;
  logic [127:0] aes_in, aes_out;
  logic [8:0]   owdata, ordata;

  function automatic logic [127:0] mk_blk(input logic [7:0] flag, input logic [31:0] ctr,
                                          input logic [63:0] n, input logic [7:0] tail);
    return {flag, ctr, n, 16'h0000, tail};
  endfunction

  assign csum = sum_q ^ SUM_MASK;

  always_comb begin
    if (cur_q.ctr == '0) begin
      case (cnt_q)
        3'd2:    trl = csum[7:0];
        3'd3:    trl = csum[15:8];
        default: trl = 8'h00;
      endcase
    end else begin
      case (cnt_q)
        3'd4:    trl = cur_q.ctr[15:8];
        3'd5:    trl = cur_q.ctr[7:0];
        default: trl = get_byte_f(chain_q, {1'b0, cnt_q}) ^ get_byte_f(ks_q, {1'b0, cnt_q});
      endcase
    end
  end

  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    chain_d    = chain_q;
    gath_d     = gath_q;
    ks_d       = ks_q;
    sum_d      = sum_q;
    bidx_d     = bidx_q;
    emit_d     = emit_q;
    cnt_d      = cnt_q;
    aes_start  = 1'b0;
    aes_in     = chain_q ^ gath_q;
    item_pop_o = 1'b0;
    opush      = 1'b0;
    owdata     = {emit_q, 1'b0};
    case (state_q)
      ST_IDLE: begin
        if (!item_empty_i) begin
          item_pop_o = 1'b1;
          cur_d      = item_i;
          state_d    = ST_HEAD;
        end
      end
      ST_HEAD: begin
        if (cur_q.first) begin
          gath_d    = '0;
          sum_d     = '0;
          bidx_d    = '0;
          aes_start = 1'b1;
          aes_in    = mk_blk(B0_FLAG, cur_q.ctr, nonce_i, cur_q.mac_len);
          state_d   = ST_B0W;
        end else begin
          state_d = ST_BODY;
        end
      end
      ST_B0W: begin
        if (aes_done) begin
          chain_d = aes_out;
          state_d = ST_BODY;
        end
      end
      ST_BODY: begin
        case (cur_q.kind)
          KIND_HDR: begin
            gath_d[{4'd15 - cur_q.k, 3'b000} +: 8] = cur_q.data;
            emit_d  = cur_q.data;
            state_d = ST_EMIT;
          end
          KIND_PAY: begin
            if (cur_q.k == 4'd0) begin
              aes_start = 1'b1;
              aes_in    = (cur_q.ctr == '0) ? FIXED_BLOCK :
                          mk_blk(CTR_FLAG, cur_q.ctr, nonce_i, bidx_q + 8'd1);
              state_d   = ST_KSW;
            end else begin
              state_d = ST_PAY;
            end
          end
          default: state_d = ST_LAST;
        endcase
      end
      ST_KSW: begin
        if (aes_done) begin
          ks_d    = aes_out;
          state_d = ST_PAY;
        end
      end
      ST_PAY: begin
        emit_d = cur_q.data ^ get_byte_f(ks_q, cur_q.k);
        sum_d  = sum_q + {8'h00, cur_q.data};
        if (cur_q.in_mac) begin
          gath_d[{4'd15 - cur_q.k, 3'b000} +: 8] = cur_q.data;
        end
        if (cur_q.k == 4'd15) begin
          bidx_d = bidx_q + 8'd1;
        end
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!ofull) begin
          opush   = 1'b1;
          state_d = ST_POST;
        end
      end
      ST_POST: begin
        if (cur_q.mac_end) begin
          aes_start = 1'b1;
          state_d   = ST_ABSW;
        end else begin
          state_d = ST_LAST;
        end
      end
      ST_ABSW: begin
        if (aes_done) begin
          chain_d = aes_out;
          gath_d  = '0;
          state_d = ST_LAST;
        end
      end
      ST_LAST: begin
        if (!cur_q.last) begin
          state_d = ST_IDLE;
        end else if (cur_q.fin_abs) begin
          aes_start = 1'b1;
          state_d   = ST_FABW;
        end else begin
          state_d = ST_TRLS;
        end
      end
      ST_FABW: begin
        if (aes_done) begin
          chain_d = aes_out;
          gath_d  = '0;
          state_d = ST_TRLS;
        end
      end
      ST_TRLS: begin
        cnt_d = '0;
        if (cur_q.ctr == '0) begin
          state_d = ST_TRL;
        end else begin
          aes_start = 1'b1;
          aes_in    = mk_blk(CTR_FLAG, cur_q.ctr, nonce_i, 8'h00);
          state_d   = ST_S0W;
        end
      end
      ST_S0W: begin
        if (aes_done) begin
          ks_d    = aes_out;
          state_d = ST_TRL;
        end
      end
      ST_TRL: begin
        owdata = {trl, (cnt_q == 3'd5)};
        if (!ofull) begin
          opush = 1'b1;
          cnt_d = cnt_q + 3'd1;
          if (cnt_q == 3'd5) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cur_q   <= '0;
      chain_q <= '0;
      gath_q  <= '0;
      sum_q   <= '0;
      bidx_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      chain_q <= chain_d;
      gath_q  <= gath_d;
      sum_q   <= sum_d;
      bidx_q  <= bidx_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ks_q   <= ks_d;
    emit_q <= emit_d;
  end

  acf_aes u_aes (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(aes_start),
    .key_i  (key_i),
    .blk_i  (aes_in),
    .done_o (aes_done),
    .blk_o  (aes_out)
  );

  acf_fifo #(
    .WIDTH(9),
    .DEPTH(OUT_FIFO_DEPTH)
  ) u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (opush),
    .wdata_i(owdata),
    .rd_i   (pop_i),
    .rdata_o(ordata),
    .full_o (ofull),
    .empty_o(empty_o)
  );

  assign out_byte_o = ordata[8:1];
  assign last_out_o = ordata[0];
endmodule

### rtl/aes_ctr_cbcmac_frame_encrypt.sv
// Top level of the AES-128 counter-mode frame encryptor with CBC-MAC trailer; with a
// zero message counter a fixed block gives the keystream and the trailer is a checksum.
// Each word passes the input queue and then the back end, which handles one word at a
// time; each AES job (B0 on the first word, keystream at each payload block start,
// each MAC absorb, the pad absorb and S0 for the tag) runs on the one shared
// round-iterative core and holds the word until it is done. After the last word the
// back end emits the trailer words, computing S0 first in counter mode.
// Reset (rst_ni low, asynchronous) clears both queues, key, nonce and state.
module aes_ctr_cbcmac_frame_encrypt import acf_pkg::*; #(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration writes
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [63:0] cfg_wdata_i,
  // Input words
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic [31:0] msg_counter_i,
  input  logic [7:0]  payload_length_i,
  input  logic        last_byte_i,
  // Result words
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte_o,
  output logic        last_out_o
);
  logic [63:0] key_low_q, key_high_q, nonce_q;
  item_t       item;
  logic        item_empty, item_pop;

  // Hold the session key and nonce; the user must write them only while idle, the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
      nonce_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_KEY_LOW:  key_low_q  <= cfg_wdata_i;
        REG_KEY_HIGH: key_high_q <= cfg_wdata_i;
        REG_NONCE:    nonce_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Classify each word by its frame position and queue it
  acf_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .full_o          (full),
    .data_byte_i     (data_byte_i),
    .msg_counter_i   (msg_counter_i),
    .payload_length_i(payload_length_i),
    .last_byte_i     (last_byte_i),
    .pop_i           (item_pop),
    .item_o          (item),
    .empty_o         (item_empty)
  );

  // Encrypt, chain the MAC and emit trailer words
  acf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_i       ({key_low_q, key_high_q}),
    .nonce_i     (nonce_q),
    .item_i      (item),
    .item_empty_i(item_empty),
    .item_pop_o  (item_pop),
    .out_byte_o  (out_byte_o),
    .last_out_o  (last_out_o),
    .empty_o     (empty),
    .pop_i       (pop)
  );
endmodule
